// ----- rtl/xhp_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and the magic table for the xpm header parser
package xhp_pkg;

   localparam int VALUE_BITS_DEFAULT = 16;
   localparam int OUT_BITS = 16;
   localparam int MAGIC_LEN = 9;
   localparam int MAGIC_POS_BITS = 4;

   localparam logic [OUT_BITS-1:0] OUT_MAX = 16'hFFFF;

   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   typedef enum logic [2:0] {
      PH_MAGIC,
      PH_SEEK,
      PH_WIDTH,
      PH_HEIGHT,
      PH_COLORS,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_NOT_XPM,
      ST_MALFORMED,
      ST_INCOMPLETE
   } status_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       first_byte;
      logic       last_byte;
   } req_word_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] image_width;
      logic [OUT_BITS-1:0] image_height;
      logic [OUT_BITS-1:0] color_count;
      status_type          parse_status;
   } rsp_word_type;

   // "/* XPM */"
   function automatic logic [7:0] magic_byte(input logic [MAGIC_POS_BITS-1:0] pos);
      logic [7:0] b;
      case (pos)
         4'd0:    b = 8'h2F;
         4'd1:    b = 8'h2A;
         4'd2:    b = 8'h20;
         4'd3:    b = 8'h58;
         4'd4:    b = 8'h50;
         4'd5:    b = 8'h4D;
         4'd6:    b = 8'h20;
         4'd7:    b = 8'h2A;
         4'd8:    b = 8'h2F;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ----- rtl/xhp_req_if.sv -----
`timescale 1ns / 1ps
// input channel: one file byte per word with start and end marks
interface xhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       first_byte;
   logic       last_byte;

   modport source (output valid, output byte_value, output first_byte, output last_byte,
                   input ready);
   modport sink (input valid, input byte_value, input first_byte, input last_byte,
                 output ready);
endinterface

// ----- rtl/xhp_rsp_if.sv -----
`timescale 1ns / 1ps
// result channel: header numbers and parse status
interface xhp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [xhp_pkg::OUT_BITS-1:0]   image_width;
   logic [xhp_pkg::OUT_BITS-1:0]   image_height;
   logic [xhp_pkg::OUT_BITS-1:0]   color_count;
   xhp_pkg::status_type            parse_status;

   modport source (output valid, output image_width, output image_height,
                   output color_count, output parse_status, input ready);
   modport sink (input valid, input image_width, input image_height,
                 input color_count, input parse_status, output ready);
endinterface

// ----- rtl/xhp_parse_core.sv -----
`timescale 1ns / 1ps
// parser state machine: magic check, quote seek and decimal field accumulation
module xhp_parse_core #(
   parameter int VALUE_BITS = xhp_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  xhp_pkg::req_word_type req_word,
   output logic                  res_valid,
   output xhp_pkg::rsp_word_type res_word
);

   localparam int SUM_BITS = VALUE_BITS + 4;
   localparam int WIDE_BITS = (VALUE_BITS > xhp_pkg::OUT_BITS) ? VALUE_BITS
                                                                 : xhp_pkg::OUT_BITS;
   localparam logic [VALUE_BITS-1:0] VALUE_LIMIT = {VALUE_BITS{1'b1}};

   xhp_pkg::phase_type                   phase_ff, phase_in, phase_cur;
   logic [xhp_pkg::MAGIC_POS_BITS-1:0]   mpos_ff, mpos_in, mpos_cur;
   logic [VALUE_BITS-1:0]                acc_ff, acc_in, acc_cur;
   logic [VALUE_BITS-1:0]                width_ff, width_in, width_cur;
   logic [VALUE_BITS-1:0]                height_ff, height_in, height_cur;

   logic                  is_digit;
   logic                  is_space;
   logic [SUM_BITS-1:0]   acc_sum;
   logic [VALUE_BITS-1:0] acc_next;
   logic                  decided;
   xhp_pkg::status_type   decided_status;
   xhp_pkg::phase_type    phase_mid;
   logic                  incomplete;

   function automatic logic [xhp_pkg::OUT_BITS-1:0] clamp_out(input logic [VALUE_BITS-1:0] v);
      logic [WIDE_BITS-1:0] w;
      w = WIDE_BITS'(v);
      return (w > WIDE_BITS'(xhp_pkg::OUT_MAX)) ? xhp_pkg::OUT_MAX
                                                : w[xhp_pkg::OUT_BITS-1:0];
   endfunction

   // a first word restarts the file before it is parsed
   always_comb begin
      if (req_word.first_byte) begin
         phase_cur  = xhp_pkg::PH_MAGIC;
         mpos_cur   = '0;
         acc_cur    = '0;
         width_cur  = '0;
         height_cur = '0;
      end else begin
         phase_cur  = phase_ff;
         mpos_cur   = mpos_ff;
         acc_cur    = acc_ff;
         width_cur  = width_ff;
         height_cur = height_ff;
      end
   end

   assign is_digit = (req_word.byte_value inside {[xhp_pkg::CHAR_ZERO:xhp_pkg::CHAR_NINE]});
   assign is_space = (req_word.byte_value == xhp_pkg::CHAR_SPACE);

   // acc * 10 + digit, saturated
   assign acc_sum = {acc_cur, 3'b000} + {2'b00, acc_cur, 1'b0}
                  + SUM_BITS'(req_word.byte_value[3:0]);
   assign acc_next = (|acc_sum[SUM_BITS-1:VALUE_BITS]) ? VALUE_LIMIT
                                                       : acc_sum[VALUE_BITS-1:0];

   // next state
   always_comb begin
      phase_in       = phase_cur;
      mpos_in        = mpos_cur;
      acc_in         = acc_cur;
      width_in       = width_cur;
      height_in      = height_cur;
      decided        = 1'b0;
      decided_status = xhp_pkg::ST_OK;
      case (phase_cur)
         xhp_pkg::PH_MAGIC: begin
            if (req_word.byte_value == xhp_pkg::magic_byte(mpos_cur)) begin
               mpos_in = mpos_cur + 1'b1;
               if (mpos_cur == xhp_pkg::MAGIC_POS_BITS'(xhp_pkg::MAGIC_LEN - 1)) begin
                  phase_in = xhp_pkg::PH_SEEK;
               end
            end else begin
               decided        = 1'b1;
               decided_status = xhp_pkg::ST_NOT_XPM;
            end
         end
         xhp_pkg::PH_SEEK: begin
            if (req_word.byte_value == xhp_pkg::CHAR_QUOTE) begin
               acc_in   = '0;
               phase_in = xhp_pkg::PH_WIDTH;
            end
         end
         xhp_pkg::PH_WIDTH, xhp_pkg::PH_HEIGHT, xhp_pkg::PH_COLORS: begin
            if (is_digit) begin
               acc_in = acc_next;
            end else if (is_space) begin
               acc_in = '0;
               if (phase_cur == xhp_pkg::PH_WIDTH) begin
                  width_in = acc_cur;
                  phase_in = xhp_pkg::PH_HEIGHT;
               end else if (phase_cur == xhp_pkg::PH_HEIGHT) begin
                  height_in = acc_cur;
                  phase_in  = xhp_pkg::PH_COLORS;
               end else begin
                  decided        = 1'b1;
                  decided_status = xhp_pkg::ST_OK;
               end
            end else begin
               decided        = 1'b1;
               decided_status = xhp_pkg::ST_MALFORMED;
            end
         end
         default: begin
            phase_in = xhp_pkg::PH_DONE;
         end
      endcase
      phase_mid  = phase_in;
      incomplete = req_word.last_byte && !decided && (phase_in != xhp_pkg::PH_DONE);
      if (decided || incomplete) begin
         phase_in = xhp_pkg::PH_DONE;
      end
   end

   // result word
   always_comb begin
      res_valid             = 1'b0;
      res_word.image_width  = '0;
      res_word.image_height = '0;
      res_word.color_count  = '0;
      res_word.parse_status = xhp_pkg::ST_OK;
      if (decided) begin
         res_valid             = 1'b1;
         res_word.parse_status = decided_status;
         case (decided_status)
            xhp_pkg::ST_OK: begin
               res_word.image_width  = clamp_out(width_cur);
               res_word.image_height = clamp_out(height_cur);
               res_word.color_count  = clamp_out(acc_cur);
            end
            xhp_pkg::ST_MALFORMED: begin
               if (phase_cur > xhp_pkg::PH_WIDTH) begin
                  res_word.image_width = clamp_out(width_cur);
               end
               if (phase_cur > xhp_pkg::PH_HEIGHT) begin
                  res_word.image_height = clamp_out(height_cur);
               end
            end
            default: begin
            end
         endcase
      end else if (incomplete) begin
         // stream ended before a decision: report what was completed
         res_valid             = 1'b1;
         res_word.parse_status = xhp_pkg::ST_INCOMPLETE;
         if (phase_mid > xhp_pkg::PH_WIDTH) begin
            res_word.image_width = clamp_out(width_in);
         end
         if (phase_mid > xhp_pkg::PH_HEIGHT) begin
            res_word.image_height = clamp_out(height_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= xhp_pkg::PH_MAGIC;
         mpos_ff   <= '0;
         acc_ff    <= '0;
         width_ff  <= '0;
         height_ff <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         mpos_ff   <= mpos_in;
         acc_ff    <= acc_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

endmodule

// ----- rtl/xpm_header_field_parser.sv -----
`timescale 1ns / 1ps
// top level of the xpm header parser: parse core plus result register
//
// channel  dir  words                    payload
// req_chan in   one per file byte        byte_value, first_byte, last_byte
// rsp_chan out  at most one per req word image_width, image_height, color_count,
//                                         parse_status
//
// one req word per cycle while req_chan.ready is high; the parse state machine updates in the accept cycle
// a result appears on rsp_chan the cycle after the deciding byte
// req_chan.ready is high while the result register is empty or being read
// synchronous reset returns the parser to the magic check with all numbers zero
module xpm_header_field_parser #(
   parameter int VALUE_BITS = xhp_pkg::VALUE_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   xhp_req_if.sink    req_chan,
   xhp_rsp_if.source  rsp_chan
);

   xhp_pkg::req_word_type req_word;
   xhp_pkg::rsp_word_type res_word;
   logic                  res_valid;
   logic                  accept;

   logic                  out_valid_ff, out_valid_in;
   xhp_pkg::rsp_word_type out_word_ff;

   assign req_word.byte_value = req_chan.byte_value;
   assign req_word.first_byte = req_chan.first_byte;
   assign req_word.last_byte  = req_chan.last_byte;

   assign req_chan.ready = !out_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   xhp_parse_core #(
      .VALUE_BITS(VALUE_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_word  (req_word),
      .res_valid (res_valid),
      .res_word  (res_word)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      if (accept) begin
         out_valid_in = res_valid;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && res_valid) begin
         out_word_ff <= res_word;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.image_width  = out_word_ff.image_width;
   assign rsp_chan.image_height = out_word_ff.image_height;
   assign rsp_chan.color_count  = out_word_ff.color_count;
   assign rsp_chan.parse_status = out_word_ff.parse_status;

endmodule
